>>> design/fdc_pkg.sv
// fdc_pkg: shared types, constants and size-code helpers for the FCM/DFCM
// double compressor. No dependencies; all design files but fdc_if use it.
`default_nettype none

package fdc_pkg;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned EPOCH_BITS   = 8;
  localparam int unsigned CTX_SHIFT    = 6;
  localparam int unsigned STR_SHIFT    = 2;
  localparam int unsigned CTX_HASH_LSB = 48;
  localparam int unsigned STR_HASH_LSB = 40;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  // Tag written by the clearing pass; live epochs never take this value
  localparam epoch_t EPOCH_CLEAR = '0;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

  // Residual size codes
  localparam logic [2:0] SIZE_0B = 3'd0;
  localparam logic [2:0] SIZE_1B = 3'd1;
  localparam logic [2:0] SIZE_2B = 3'd2;
  localparam logic [2:0] SIZE_3B = 3'd3;
  localparam logic [2:0] SIZE_5B = 3'd4;
  localparam logic [2:0] SIZE_6B = 3'd5;
  localparam logic [2:0] SIZE_7B = 3'd6;
  localparam logic [2:0] SIZE_8B = 3'd7;

  // One table word: epoch tag plus stored value
  typedef struct packed {
    epoch_t tag;
    value_t data;
  } tbl_entry_t;

  // Both residuals of one item, handed from front to back
  typedef struct packed {
    value_t r_ctx;
    value_t r_str;
    logic   last;
  } resid_pair_t;

  // Leading-zero-byte size code; a four-byte residual is coded as five bytes
  function automatic logic [2:0] size_code_of(value_t r);
    logic [2:0] c;
    priority if (r == '0)               c = SIZE_0B;
    else if (r[VALUE_BITS-1:8] == '0)   c = SIZE_1B;
    else if (r[VALUE_BITS-1:16] == '0)  c = SIZE_2B;
    else if (r[VALUE_BITS-1:24] == '0)  c = SIZE_3B;
    else if (r[VALUE_BITS-1:40] == '0)  c = SIZE_5B;
    else if (r[VALUE_BITS-1:48] == '0)  c = SIZE_6B;
    else if (r[VALUE_BITS-1:56] == '0)  c = SIZE_7B;
    else                                c = SIZE_8B;
    return c;
  endfunction

  // Byte count for a size code: code + (code >> 2)
  function automatic logic [3:0] bytes_of(logic [2:0] code);
    return 4'(code) + 4'(code[2]);
  endfunction

endpackage

`default_nettype wire

>>> design/fdc_if.sv
// fdc_if: valid/ready stream interfaces for the sample input and the code
// output of the compressor. No dependencies.
`default_nettype none

interface fdc_sample_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_bits;
  logic        last_in_block;

  modport source(output valid, sample_bits, last_in_block, input ready);
  modport sink(input valid, sample_bits, last_in_block, output ready);
endinterface

interface fdc_code_if;
  logic        valid;
  logic        ready;
  logic        use_stride;
  logic [2:0]  size_code;
  logic [63:0] residual;
  logic [3:0]  residual_bytes;
  logic        block_end;

  modport source(output valid, use_stride, size_code, residual, residual_bytes, block_end,
                 input ready);
  modport sink(input valid, use_stride, size_code, residual, residual_bytes, block_end,
               output ready);
endinterface

`default_nettype wire

>>> design/fdc_table.sv
// fdc_table: one prediction table, a single-port-write / single-port-read
// memory with registered read data. Depends on fdc_pkg.
`default_nettype none

module fdc_table #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [INDEX_BITS-1:0]  wr_addr,
  input  wire fdc_pkg::tbl_entry_t    wr_data,
  input  wire logic                   rd_en,
  input  wire logic [INDEX_BITS-1:0]  rd_addr,
  output fdc_pkg::tbl_entry_t         rd_data
);

  localparam int unsigned DEPTH = 2 ** INDEX_BITS;

  fdc_pkg::tbl_entry_t mem [DEPTH];

  // Write and read; a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/fdc_front.sv
// fdc_front: accepts samples, forms both predictions, updates the context
// and stride tables and hashes, and pushes both residuals to the queue.
// Depends on fdc_pkg, fdc_if and fdc_table.
`default_nettype none

module fdc_front #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  fdc_sample_if.sink                samples,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output fdc_pkg::resid_pair_t      push_data
);

  logic                    sweeping;
  logic [INDEX_BITS-1:0]   sweep_addr;
  fdc_pkg::epoch_t         epoch;
  logic                    live;
  logic [INDEX_BITS-1:0]   ctx_idx;
  logic [INDEX_BITS-1:0]   str_idx;
  fdc_pkg::value_t         prev;

  logic                    ctx_fwd_hit;
  logic                    str_fwd_hit;
  fdc_pkg::value_t         ctx_fwd_val;
  fdc_pkg::value_t         str_fwd_val;

  fdc_pkg::tbl_entry_t     ctx_rd;
  fdc_pkg::tbl_entry_t     str_rd;
  fdc_pkg::tbl_entry_t     ctx_wr;
  fdc_pkg::tbl_entry_t     str_wr;
  logic [INDEX_BITS-1:0]   ctx_wr_addr;
  logic [INDEX_BITS-1:0]   str_wr_addr;
  logic                    tbl_wr_en;

  logic                    accept;
  fdc_pkg::value_t         v;
  fdc_pkg::value_t         stride;
  fdc_pkg::value_t         ctx_pred;
  fdc_pkg::value_t         str_pred;
  logic [INDEX_BITS-1:0]   ctx_idx_next;
  logic [INDEX_BITS-1:0]   str_idx_next;

  // Handshake: hold off during the clearing pass or when the queue is full
  assign samples.ready = !sweeping && push_ready;
  assign accept        = samples.valid && samples.ready;
  assign v             = samples.sample_bits;

  // Hashes and stride
  assign stride       = v - prev;
  assign ctx_idx_next = (ctx_idx << fdc_pkg::CTX_SHIFT)
                        ^ INDEX_BITS'(v >> fdc_pkg::CTX_HASH_LSB);
  assign str_idx_next = (str_idx << fdc_pkg::STR_SHIFT)
                        ^ INDEX_BITS'(stride >> fdc_pkg::STR_HASH_LSB);

  // Predictions: zero at block start; forward same-index writes, drop words from stale epochs
  always_comb begin
    if (!live) begin
      ctx_pred = '0;
    end else if (ctx_fwd_hit) begin
      ctx_pred = ctx_fwd_val;
    end else if (ctx_rd.tag == epoch) begin
      ctx_pred = ctx_rd.data;
    end else begin
      ctx_pred = '0;
    end
  end

  always_comb begin
    if (!live) begin
      str_pred = '0;
    end else if (str_fwd_hit) begin
      str_pred = str_fwd_val;
    end else if (str_rd.tag == epoch) begin
      str_pred = str_rd.data;
    end else begin
      str_pred = '0;
    end
  end

  // Residuals to the queue
  assign push_valid      = accept;
  assign push_data.r_ctx = v ^ ctx_pred;
  assign push_data.r_str = v ^ (prev + str_pred);
  assign push_data.last  = samples.last_in_block;

  // Table write port: clearing pass or item update
  assign tbl_wr_en   = sweeping || accept;
  assign ctx_wr_addr = sweeping ? sweep_addr : ctx_idx;
  assign str_wr_addr = sweeping ? sweep_addr : str_idx;
  assign ctx_wr.tag  = sweeping ? fdc_pkg::EPOCH_CLEAR : epoch;
  assign ctx_wr.data = sweeping ? '0 : v;
  assign str_wr.tag  = sweeping ? fdc_pkg::EPOCH_CLEAR : epoch;
  assign str_wr.data = sweeping ? '0 : stride;

  fdc_table #(.INDEX_BITS(INDEX_BITS)) u_ctx_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (ctx_wr_addr),
    .wr_data (ctx_wr),
    .rd_en   (accept),
    .rd_addr (ctx_idx_next),
    .rd_data (ctx_rd)
  );

  fdc_table #(.INDEX_BITS(INDEX_BITS)) u_str_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (str_wr_addr),
    .wr_data (str_wr),
    .rd_en   (accept),
    .rd_addr (str_idx_next),
    .rd_data (str_rd)
  );

  // Control state: clearing pass, epoch, hashes, previous value
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      epoch      <= fdc_pkg::EPOCH_FIRST;
      live       <= 1'b0;
      ctx_idx    <= '0;
      str_idx    <= '0;
      prev       <= '0;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (&sweep_addr) begin
          sweeping <= 1'b0;
        end
      end
      if (accept) begin
        if (samples.last_in_block) begin
          live    <= 1'b0;
          ctx_idx <= '0;
          str_idx <= '0;
          prev    <= '0;
          if (epoch == fdc_pkg::EPOCH_LAST) begin
            epoch    <= fdc_pkg::EPOCH_FIRST;
            sweeping <= 1'b1;
          end else begin
            epoch <= epoch + 1'b1;
          end
        end else begin
          live    <= 1'b1;
          ctx_idx <= ctx_idx_next;
          str_idx <= str_idx_next;
          prev    <= v;
        end
      end
    end
  end

  // Forwarding for a next index equal to the one written this beat
  always_ff @(posedge clk) begin
    if (accept) begin
      ctx_fwd_hit <= (ctx_idx_next == ctx_idx);
      ctx_fwd_val <= v;
      str_fwd_hit <= (str_idx_next == str_idx);
      str_fwd_val <= stride;
    end
  end

`ifndef SYNTHESIS
  a_block_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && samples.last_in_block |=>
      !live && ctx_idx == '0 && str_idx == '0 && prev == '0)
    else $error("state not cleared after block end");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> sweeping && sweep_addr == '0 && !samples.ready)
    else $error("clearing pass not started after reset");

  a_live_epoch_not_clear: assert property (@(posedge clk) disable iff (rst)
    epoch != fdc_pkg::EPOCH_CLEAR)
    else $error("epoch took the clearing tag");
`endif

endmodule

`default_nettype wire

>>> design/fdc_queue.sv
// fdc_queue: short FIFO of residual pairs between front and back.
// Depends on fdc_pkg.
`default_nettype none

module fdc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire fdc_pkg::resid_pair_t push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output fdc_pkg::resid_pair_t      pop_data
);

  localparam int unsigned PTR_BITS = $clog2(fdc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(fdc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(fdc_pkg::QUEUE_DEPTH);

  fdc_pkg::resid_pair_t  slots [fdc_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("front pushed into a full queue");
`endif

endmodule

`default_nettype wire

>>> design/fdc_back.sv
// fdc_back: picks the smaller residual, forms the size code and byte count,
// and holds the result in the output register. Depends on fdc_pkg, fdc_if.
`default_nettype none

module fdc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire fdc_pkg::resid_pair_t pop_data,
  fdc_code_if.source                codes
);

  logic             out_valid;
  logic             out_use_stride;
  logic [2:0]       out_size_code;
  fdc_pkg::value_t  out_residual;
  logic [3:0]       out_bytes;
  logic             out_block_end;

  logic             take;
  logic             sel;
  fdc_pkg::value_t  r;
  logic [2:0]       code;

  // Take the next pair when the output register is free or draining
  assign pop_ready = !out_valid || codes.ready;
  assign take      = pop_valid && pop_ready;

  // Select residual; ties go to the context side
  assign sel  = pop_data.r_ctx > pop_data.r_str;
  assign r    = sel ? pop_data.r_str : pop_data.r_ctx;
  assign code = fdc_pkg::size_code_of(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_use_stride <= sel;
      out_size_code  <= code;
      out_residual   <= r;
      out_bytes      <= fdc_pkg::bytes_of(code);
      out_block_end  <= pop_data.last;
    end
  end

  assign codes.valid          = out_valid;
  assign codes.use_stride     = out_use_stride;
  assign codes.size_code      = out_size_code;
  assign codes.residual       = out_residual;
  assign codes.residual_bytes = out_bytes;
  assign codes.block_end      = out_block_end;

`ifndef SYNTHESIS
  a_bytes_cover_residual: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_residual >> {out_bytes, 3'b000}) == '0)
    else $error("residual has bytes beyond its byte count");
`endif

endmodule

`default_nettype wire

>>> design/fcm_dfcm_double_compressor_top.sv
// Channel   Dir  Payload                                            Beat
// samples   in   sample_bits[63:0], last_in_block                   one double
// codes     out  use_stride, size_code[2:0], residual[63:0],        one code
//                residual_bytes[3:0], block_end
//
// Sustains one sample per cycle while the queue has room and no clearing
// pass runs; the table read-modify-write with a one-deep forward on an
// unchanged index sets that rate. Residuals wait in the queue, codes in
// the output register. After reset, and after every 255th block end, a
// clearing pass walks both tables with samples.ready low.
// While codes.ready is low, the two-entry queue and the output register take
// up to three samples; after that samples.ready drops until the output drains.
// Depends on fdc_pkg, fdc_if, fdc_front, fdc_queue, fdc_back.
`default_nettype none

module fcm_dfcm_double_compressor_top #(
  parameter int unsigned TABLE_INDEX_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  fdc_sample_if.sink samples,
  fdc_code_if.source codes
);

  logic                  push_valid;
  logic                  push_ready;
  fdc_pkg::resid_pair_t  push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  fdc_pkg::resid_pair_t  pop_data;

  fdc_front #(.INDEX_BITS(TABLE_INDEX_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .codes     (codes)
  );

endmodule

`default_nettype wire
